// File: rtl/mctb_pkg.sv
// Shared types and constants for the multi-channel soft timer bank.
// Used by the timer bank top level; no dependencies.
package mctb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int TICK_BITS  = 32;
  localparam int CH_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MAX_OUT    = 8;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_DELETE = 3'd3,
    OP_TICK   = 3'd4,
    OP_QUERY  = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CREATED = 3'd0,
    ST_STARTED = 3'd1,
    ST_RUNNING = 3'd2,
    ST_STOPPED = 3'd3,
    ST_DELETED = 3'd4
  } tstate_t;

  localparam logic KIND_FIRE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // One channel's record as kept in the state memory.
  typedef struct packed {
    logic [TICK_BITS-1:0] cnt;
    logic [TICK_BITS-1:0] dly;
    logic [TICK_BITS-1:0] per;
    logic [2:0]           st;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t RESET_ENTRY = '{
    cnt: '0,
    dly: '0,
    per: '0,
    st:  ST_DELETED
  };

  typedef struct packed {
    logic        kind;
    logic [2:0]  id;
    logic [2:0]  st;
    logic [31:0] dly;
    logic [31:0] per;
    logic [31:0] rem;
    logic        last;
  } result_t;

endpackage

// File: rtl/mctb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mctb_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/multi_channel_soft_timer_bank.sv
// Top level of the multi-channel soft timer bank: command decode, tick scan,
// result buffering. Depends on mctb_pkg and mctb_ram.
//
// Each command transaction is a read-modify-write of one channel record in a
// RAM with registered read data: init, start, stop, delete and query pass
// through the command state and back to idle before the next command can be
// accepted (query may wait longer for the output register to drain). A tick
// walks the channels one per cycle through the same RAM port, holding while a
// fire result cannot be passed on, then ends in a flush state.
// Fire results come out in channel order; one fire result is held back until
// the next fire or the end of the scan so that the final result of a tick
// carries tlast. Channel records come out of reset as deleted with zero settings
// and count, through per-channel valid flags; no clearing pass is needed.
module multi_channel_soft_timer_bank (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // opcode[2:0], channel[5:3], start_delay[37:6],
                                   // period[69:38], zero pad[71:70]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // timer_id[2:0], timer_state[5:3],
                                   // delay_value[37:6], period_value[69:38],
                                   // remaining[101:70], zero pad[103:102]
  output logic         out_tuser,  // kind
  output logic         out_tlast   // last
);

  localparam int N  = mctb_pkg::NUM_TIMERS;
  localparam int TB = mctb_pkg::TICK_BITS;
  localparam int CW = mctb_pkg::CH_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMD,
    S_TICK,
    S_FLUSH
  } state_t;

  state_t                state_r, state_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [2:0]            ch_r, ch_nxt;
  logic                  chok_r, chok_nxt;
  logic [TB-1:0]         dly_in_r, dly_in_nxt;
  logic [TB-1:0]         per_in_r, per_in_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  logic [3:0]            n_r, n_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  mctb_pkg::result_t     pend_r, pend_nxt;
  logic                  out_vld_r, out_vld_nxt;
  mctb_pkg::result_t     out_r, out_nxt;
  logic [N-1:0]          vld_r, vld_nxt;
  logic                  rd_vld_r;

  logic                  rd_en, we;
  logic [CW-1:0]         rd_addr, wr_addr;
  mctb_pkg::entry_t      rd_data, ent, wd;

  logic [2:0]            in_op, in_ch;
  logic                  in_chok;
  logic                  out_free;

  // tick evaluation of the channel under scan
  logic                  t_armed, t_fire, t_rep, t_stall;
  mctb_pkg::entry_t      t_new;
  mctb_pkg::result_t     t_res, q_res;

  assign in_op   = in_tdata[2:0];
  assign in_ch   = in_tdata[5:3];
  assign in_chok = (32'(in_ch) < 32'(N));

  mctb_ram #(
    .WIDTH (mctb_pkg::ENTRY_W),
    .DEPTH (N)
  ) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wd),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // A never-written record reads as its reset value.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign ent      = rd_vld_r ? rd_data : mctb_pkg::RESET_ENTRY;
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    t_armed = (ent.st == mctb_pkg::ST_STARTED);
    t_fire  = t_armed && ((ent.cnt == '0) || (ent.cnt == TB'(1)));
    t_new   = ent;
    if (t_armed) begin
      if (ent.cnt != '0) begin
        t_new.cnt = ent.cnt - TB'(1);
      end
      if (t_fire) begin
        if (ent.per != '0) begin
          t_new.cnt = ent.per;
        end else begin
          t_new.st = mctb_pkg::ST_STOPPED;
        end
      end
    end
    t_rep   = (n_r < 4'(mctb_pkg::MAX_OUT));
    t_stall = t_fire && t_rep && pend_vld_r && !out_free;

    t_res.kind = mctb_pkg::KIND_FIRE;
    t_res.id   = 3'(scan_r);
    t_res.st   = t_new.st;
    t_res.dly  = 32'(t_new.dly);
    t_res.per  = 32'(t_new.per);
    t_res.rem  = 32'(t_new.cnt);
    t_res.last = 1'b0;

    q_res.kind = mctb_pkg::KIND_QUERY;
    q_res.id   = ch_r;
    q_res.last = 1'b1;
    if (chok_r) begin
      q_res.st  = ent.st;
      q_res.dly = 32'(ent.dly);
      q_res.per = 32'(ent.per);
      q_res.rem = 32'(ent.cnt);
    end else begin
      q_res.st  = mctb_pkg::ST_DELETED;
      q_res.dly = '0;
      q_res.per = '0;
      q_res.rem = '0;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    ch_nxt       = ch_r;
    chok_nxt     = chok_r;
    dly_in_nxt   = dly_in_r;
    per_in_nxt   = per_in_r;
    scan_nxt     = scan_r;
    n_nxt        = n_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    vld_nxt      = vld_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    we           = 1'b0;
    wr_addr      = CW'(ch_r);
    wd           = ent;
    in_tready    = (state_r == S_IDLE);

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_op;
          ch_nxt     = in_ch;
          chok_nxt   = in_chok;
          dly_in_nxt = TB'(in_tdata[37:6]);
          per_in_nxt = TB'(in_tdata[69:38]);
          unique case (in_op) inside
            mctb_pkg::OP_TICK: begin
              rd_en        = 1'b1;
              rd_addr      = '0;
              scan_nxt     = '0;
              n_nxt        = '0;
              pend_vld_nxt = 1'b0;
              state_nxt    = S_TICK;
            end
            mctb_pkg::OP_INIT, mctb_pkg::OP_START, mctb_pkg::OP_STOP,
            mctb_pkg::OP_DELETE, mctb_pkg::OP_QUERY: begin
              rd_en     = in_chok;
              rd_addr   = CW'(in_ch);
              state_nxt = S_CMD;
            end
            default: begin
              // unused opcodes: drop the transaction
            end
          endcase
        end
      end

      S_CMD: begin
        state_nxt = S_IDLE;
        unique case (op_r)
          mctb_pkg::OP_INIT: begin
            wd.dly = dly_in_r;
            wd.per = per_in_r;
            wd.cnt = (dly_in_r != '0) ? dly_in_r : per_in_r;
            wd.st  = mctb_pkg::ST_CREATED;
            we     = chok_r;
          end
          mctb_pkg::OP_START: begin
            wd.cnt = (ent.dly != '0) ? ent.dly : ent.per;
            wd.st  = mctb_pkg::ST_STARTED;
            we     = chok_r && ((ent.st == mctb_pkg::ST_CREATED) ||
                                (ent.st == mctb_pkg::ST_STARTED));
          end
          mctb_pkg::OP_STOP: begin
            wd.st = mctb_pkg::ST_STOPPED;
            we    = chok_r && (ent.st == mctb_pkg::ST_STARTED);
          end
          mctb_pkg::OP_DELETE: begin
            wd.st = mctb_pkg::ST_DELETED;
            we    = chok_r;
          end
          mctb_pkg::OP_QUERY: begin
            // hold until the output register can take the answer
            if (out_free) begin
              out_vld_nxt = 1'b1;
              out_nxt     = q_res;
            end else begin
              state_nxt = S_CMD;
            end
          end
          default: begin
          end
        endcase
        if (we) begin
          vld_nxt[CW'(ch_r)] = 1'b1;
        end
      end

      S_TICK: begin
        wr_addr = scan_r;
        wd      = t_new;
        if (!t_stall) begin
          if (t_armed) begin
            we              = 1'b1;
            vld_nxt[scan_r] = 1'b1;
          end
          if (t_fire && t_rep) begin
            if (pend_vld_r) begin
              out_vld_nxt = 1'b1;
              out_nxt     = pend_r;
            end
            pend_nxt     = t_res;
            pend_vld_nxt = 1'b1;
            n_nxt        = n_r + 4'd1;
          end
          if (scan_r == CW'(N - 1)) begin
            state_nxt = S_FLUSH;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = scan_r + CW'(1);
            scan_nxt = scan_r + CW'(1);
          end
        end
      end

      S_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_vld_nxt      = 1'b1;
          out_nxt          = pend_r;
          out_nxt.last     = 1'b1;
          pend_vld_nxt     = 1'b0;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      vld_r      <= '0;
      n_r        <= '0;
      scan_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      vld_r      <= vld_nxt;
      n_r        <= n_nxt;
      scan_r     <= scan_nxt;
    end
    op_r     <= op_nxt;
    ch_r     <= ch_nxt;
    chok_r   <= chok_nxt;
    dly_in_r <= dly_in_nxt;
    per_in_r <= per_in_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_r.rem, out_r.per, out_r.dly, out_r.st, out_r.id};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

endmodule

// File: verif/tb_multi_channel_soft_timer_bank.sv
// Self-checking testbench for the multi-channel soft timer bank: directed and random
// command streams with random stalls on both sides and one long result-side hold-off.
// Depends on mctb_pkg and the multi_channel_soft_timer_bank RTL.
module tb_multi_channel_soft_timer_bank;

  // Unused opcodes: the block must ignore them.
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int RANDOM_CMDS = 180;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 300;

  class timer_bank_scoreboard;
    logic [31:0]          cnt_q [mctb_pkg::NUM_TIMERS];
    logic [31:0]          dly_q [mctb_pkg::NUM_TIMERS];
    logic [31:0]          per_q [mctb_pkg::NUM_TIMERS];
    mctb_pkg::tstate_t    st_q  [mctb_pkg::NUM_TIMERS];
    mctb_pkg::result_t    owed_results [$];
    int                   errors;

    function new();
      for (int c = 0; c < mctb_pkg::NUM_TIMERS; c++) begin
        cnt_q[c] = '0;
        dly_q[c] = '0;
        per_q[c] = '0;
        st_q[c]  = mctb_pkg::ST_DELETED;
      end
      errors = 0;
    endfunction

    function mctb_pkg::result_t snapshot(logic kind, int c);
      mctb_pkg::result_t r;
      r.kind = kind;
      r.id   = c[2:0];
      r.st   = st_q[c];
      r.dly  = dly_q[c];
      r.per  = per_q[c];
      r.rem  = cnt_q[c];
      r.last = 1'b0;
      return r;
    endfunction

    // Update the channel state for one accepted command and queue what it owes.
    function void apply_command(logic [71:0] d);
      logic [2:0]        op;
      int                ch;
      logic [31:0]       dly;
      logic [31:0]       per;
      mctb_pkg::result_t held;
      bit                have_held;
      bit                fire;
      int                n;
      op  = d[2:0];
      ch  = d[5:3];
      dly = d[37:6];
      per = d[69:38];
      have_held = 0;
      n = 0;
      case (op)
        mctb_pkg::OP_INIT: begin
          dly_q[ch] = dly;
          per_q[ch] = per;
          cnt_q[ch] = (dly != 0) ? dly : per;
          st_q[ch]  = mctb_pkg::ST_CREATED;
        end
        mctb_pkg::OP_START: begin
          if (st_q[ch] == mctb_pkg::ST_CREATED || st_q[ch] == mctb_pkg::ST_STARTED) begin
            cnt_q[ch] = (dly_q[ch] != 0) ? dly_q[ch] : per_q[ch];
            st_q[ch]  = mctb_pkg::ST_STARTED;
          end
        end
        mctb_pkg::OP_STOP: begin
          if (st_q[ch] == mctb_pkg::ST_STARTED) st_q[ch] = mctb_pkg::ST_STOPPED;
        end
        mctb_pkg::OP_DELETE: st_q[ch] = mctb_pkg::ST_DELETED;
        mctb_pkg::OP_TICK: begin
          for (int c = 0; c < mctb_pkg::NUM_TIMERS; c++) begin
            if (st_q[c] == mctb_pkg::ST_STARTED) begin
              if (cnt_q[c] == 0) begin
                fire = 1;
              end else begin
                cnt_q[c] = cnt_q[c] - 1;
                fire = (cnt_q[c] == 0);
              end
              if (fire) begin
                if (per_q[c] != 0) cnt_q[c] = per_q[c];
                else st_q[c] = mctb_pkg::ST_STOPPED;
                if (n < mctb_pkg::MAX_OUT) begin
                  // Hold one fire back so the final one can carry last.
                  if (have_held) owed_results.push_back(held);
                  held = snapshot(mctb_pkg::KIND_FIRE, c);
                  have_held = 1;
                  n++;
                end
              end
            end
          end
          if (have_held) begin
            held.last = 1'b1;
            owed_results.push_back(held);
          end
        end
        mctb_pkg::OP_QUERY: begin
          held = snapshot(mctb_pkg::KIND_QUERY, ch);
          held.last = 1'b1;
          owed_results.push_back(held);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [103:0] data, logic user, logic lastf);
      mctb_pkg::result_t got;
      mctb_pkg::result_t want;
      got.kind = user;
      got.id   = data[2:0];
      got.st   = data[5:3];
      got.dly  = data[37:6];
      got.per  = data[69:38];
      got.rem  = data[101:70];
      got.last = lastf;
      if (owed_results.size() == 0) begin
        report_mismatch("result with nothing pending, timer_id", got.id, 0);
      end else begin
        want = owed_results.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.id !== want.id) report_mismatch("timer_id", got.id, want.id);
        if (got.st !== want.st) report_mismatch("timer_state", got.st, want.st);
        if (got.dly !== want.dly) report_mismatch("delay_value", got.dly, want.dly);
        if (got.per !== want.per) report_mismatch("period_value", got.per, want.per);
        if (got.rem !== want.rem) report_mismatch("remaining", got.rem, want.rem);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
        if (data[103:102] !== 2'b00) report_mismatch("pad bits", data[103:102], 0);
      end
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  timer_bank_scoreboard books;
  int issued_cmds = 0;

  multi_channel_soft_timer_bank u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (r < 60) g = 0;
    else if (r < 92) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    return g;
  endfunction

  // Offer one command transaction; entered and left at a falling edge.
  task automatic send_cmd(logic [2:0] op, logic [2:0] ch, logic [31:0] dly,
                          logic [31:0] per);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, per, dly, ch, op};
    do @(posedge clk); while (!in_tready);
    books.apply_command({2'b00, per, dly, ch, op});
    if (op != OP_RSVD6 && op != OP_RSVD7) issued_cmds++;
    @(negedge clk);
  endtask

  task automatic set_up_channel(logic [2:0] ch, logic [31:0] dly, logic [31:0] per);
    send_cmd(mctb_pkg::OP_INIT, ch, dly, per);
    send_cmd(mctb_pkg::OP_START, ch, $urandom, $urandom);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) books.check_result(out_tdata, out_tuser, out_tlast);
  end

  // Result side: random stalls, plus one long hold-off once traffic is under way.
  initial begin
    int n;
    bit held_off;
    held_off = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && issued_cmds >= HOLD_AT) begin
        held_off = 1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(negedge clk);
        end
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8) - 1) @(negedge clk);
    end
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int r;
    logic [2:0] ch;
    books = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset state, zero count firing at once, extremes, ignored commands.
    send_cmd(mctb_pkg::OP_QUERY, 3'd0, 32'h0, 32'h0);
    send_cmd(mctb_pkg::OP_START, 3'd0, 32'h0, 32'h0);
    send_cmd(mctb_pkg::OP_INIT, 3'd0, 32'h0, 32'h0);
    send_cmd(mctb_pkg::OP_START, 3'd0, 32'h0, 32'h0);
    send_cmd(mctb_pkg::OP_TICK, 3'd0, 32'h0, 32'h0);
    send_cmd(mctb_pkg::OP_START, 3'd0, 32'h0, 32'h0);
    send_cmd(mctb_pkg::OP_QUERY, 3'd0, 32'h0, 32'h0);
    set_up_channel(3'd1, 32'd1, 32'd2);
    set_up_channel(3'd2, 32'd0, 32'hFFFF_FFFF);
    set_up_channel(3'd3, 32'hFFFF_FFFF, 32'd1);
    send_cmd(mctb_pkg::OP_STOP, 3'd3, 32'h0, 32'h0);
    send_cmd(mctb_pkg::OP_STOP, 3'd4, 32'h0, 32'h0);
    send_cmd(mctb_pkg::OP_TICK, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(mctb_pkg::OP_INIT, 3'd1, 32'd5, 32'd7);
    send_cmd(mctb_pkg::OP_QUERY, 3'd1, 32'h0, 32'h0);
    send_cmd(mctb_pkg::OP_DELETE, 3'd2, 32'h0, 32'h0);
    send_cmd(mctb_pkg::OP_QUERY, 3'd2, 32'h0, 32'h0);
    send_cmd(OP_RSVD6, 3'd5, 32'h1234_5678, 32'h9ABC_DEF0);
    send_cmd(OP_RSVD7, 3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(mctb_pkg::OP_QUERY, 3'd3, 32'h0, 32'h0);
    send_cmd(mctb_pkg::OP_START, 3'd3, 32'h0, 32'h0);
    send_cmd(mctb_pkg::OP_QUERY, 3'd7, 32'h0, 32'h0);

    // Random: mostly set-up sequences with short counts and ticks to make them fire.
    while (issued_cmds < RANDOM_CMDS + 25) begin
      r  = $urandom_range(0, 99);
      ch = 3'($urandom_range(0, mctb_pkg::NUM_TIMERS - 1));
      if (r < 33) begin
        set_up_channel(ch, $urandom_range(0, 4),
                       ($urandom_range(0, 9) < 3) ? 32'd0 : $urandom_range(1, 5));
      end else if (r < 63) begin
        send_cmd(mctb_pkg::OP_TICK, ch, $urandom, $urandom);
      end else if (r < 73) begin
        send_cmd(mctb_pkg::OP_QUERY, ch, $urandom, $urandom);
      end else if (r < 78) begin
        send_cmd(mctb_pkg::OP_STOP, ch, $urandom, $urandom);
      end else if (r < 81) begin
        send_cmd(mctb_pkg::OP_DELETE, ch, $urandom, $urandom);
      end else if (r < 86) begin
        send_cmd(mctb_pkg::OP_START, ch, $urandom, $urandom);
      end else if (r < 91) begin
        send_cmd(mctb_pkg::OP_INIT, ch, $urandom, $urandom);
        if ($urandom_range(0, 1)) send_cmd(mctb_pkg::OP_START, ch, $urandom, $urandom);
      end else if (r < 95) begin
        send_cmd($urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7, ch, $urandom, $urandom);
      end else begin
        // Arm every channel with a short delay, then tick enough for every channel to fire.
        for (int k = 0; k < mctb_pkg::NUM_TIMERS; k++)
          set_up_channel(3'(k), $urandom_range(1, 2), $urandom_range(0, 3));
        repeat (3) send_cmd(mctb_pkg::OP_TICK, ch, $urandom, $urandom);
      end
    end
    in_tvalid <= 1'b0;

    while (books.owed_results.size() != 0) @(posedge clk);
    repeat (4 * mctb_pkg::NUM_TIMERS) @(posedge clk);
    if (books.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: multi_channel_soft_timer_bank.f
rtl/mctb_pkg.sv
rtl/mctb_ram.sv
rtl/multi_channel_soft_timer_bank.sv
verif/tb_multi_channel_soft_timer_bank.sv
